@@ hw/rtl/crm_pkg.sv @@
// Package with the key, frame constants and pipeline lane type of the response mixer.
`timescale 1ns / 1ps
`default_nettype none

package crm_pkg;

    localparam logic [63:0] MIX_KEY      = 64'h5461a928b17834df;
    localparam logic [7:0]  FRAME_HEADER = 8'h06;
    localparam logic [7:0]  FRAME_LENGTH = 8'h08;

    typedef struct packed {
        logic        valid;
        logic [63:0] x;
        logic [63:0] y;
    } lane_t;

    // Rotates the key left by the given amount.
    function automatic logic [63:0] rotl_key(input logic [5:0] amount);
        logic [127:0] doubled;
        doubled = {MIX_KEY, MIX_KEY} << amount;
        return doubled[127:64];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crm_chal_if.sv @@
// Handshake interface that carries challenge transfers.
`timescale 1ns / 1ps
`default_nettype none

interface crm_chal_if;
    logic        valid;
    logic        ready;
    logic [63:0] challenge;

    modport source (output valid, output challenge, input ready);
    modport sink (input valid, input challenge, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crm_resp_if.sv @@
// Handshake interface that carries response transfers.
`timescale 1ns / 1ps
`default_nettype none

interface crm_resp_if;
    logic        valid;
    logic        ready;
    logic [63:0] response;
    logic [7:0]  frame_checksum;

    modport source (output valid, output response, output frame_checksum, input ready);
    modport sink (input valid, input response, input frame_checksum, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crm_prep.sv @@
// Entry stage that whitens the challenge with the key.
`timescale 1ns / 1ps
`default_nettype none

module crm_prep
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    crm_chal_if.sink           chal,
    output crm_pkg::lane_t     lane
);

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] x_reg;
    logic [63:0] x_next;

    assign chal.ready = advance;

    always_comb
    begin
        valid_next = chal.valid;
        x_next     = (chal.challenge + crm_pkg::MIX_KEY) ^ crm_pkg::MIX_KEY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= x_next;
        end
    end

    assign lane.valid = valid_reg;
    assign lane.x     = x_reg;
    assign lane.y     = 64'd0;

endmodule

`default_nettype wire

@@ hw/rtl/crm_round.sv @@
// One mixing round split over four register stages, one wide add in each.
`timescale 1ns / 1ps
`default_nettype none

module crm_round
#(
    parameter int ROUND_INDEX = 0
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  crm_pkg::lane_t     lane_in,
    output crm_pkg::lane_t     lane_out
);

    localparam logic [5:0]  ROT_AMOUNT = 6'(ROUND_INDEX % 64);
    localparam logic [63:0] ROUND_KEY  = crm_pkg::rotl_key(ROT_AMOUNT);

    logic [3:0]  valid_reg;
    logic [3:0]  valid_next;
    logic [63:0] a_x_reg;
    logic [63:0] a_x_next;
    logic [63:0] b_x_reg;
    logic [63:0] b_x_next;
    logic [63:0] b_y_reg;
    logic [63:0] b_y_next;
    logic [63:0] c_x_reg;
    logic [63:0] c_y_reg;
    logic [63:0] c_s_reg;
    logic [63:0] c_s_next;
    logic [63:0] d_x_reg;
    logic [63:0] d_x_next;
    logic [63:0] d_y_reg;

    always_comb
    begin
        valid_next = {valid_reg[2:0], lane_in.valid};
        a_x_next   = (lane_in.x + lane_in.y) ^ ROUND_KEY;
        b_y_next   = crm_pkg::MIX_KEY ^ (crm_pkg::MIX_KEY + (a_x_reg ^ crm_pkg::MIX_KEY));
        b_x_next   = a_x_reg ^ b_y_next;
        c_s_next   = (crm_pkg::MIX_KEY + b_x_reg) ^ b_y_reg;
        d_x_next   = c_x_reg + c_s_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 4'b0000;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_x_reg <= a_x_next;
            b_x_reg <= b_x_next;
            b_y_reg <= b_y_next;
            c_x_reg <= b_x_reg;
            c_y_reg <= b_y_reg;
            c_s_reg <= c_s_next;
            d_x_reg <= d_x_next;
            d_y_reg <= c_y_reg;
        end
    end

    assign lane_out.valid = valid_reg[3];
    assign lane_out.x     = d_x_reg;
    assign lane_out.y     = d_y_reg;

endmodule

`default_nettype wire

@@ hw/rtl/crm_out.sv @@
// Output register stage that forms the frame checksum and drives the response channel.
`timescale 1ns / 1ps
`default_nettype none

module crm_out
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  crm_pkg::lane_t     lane,
    output logic               advance,
    crm_resp_if.source         resp
);

    logic        valid_reg;
    logic        valid_next;
    logic [63:0] response_reg;
    logic [7:0]  checksum_reg;
    logic [7:0]  checksum_next;

    assign advance = !valid_reg || resp.ready;

    always_comb
    begin
        valid_next    = lane.valid;
        checksum_next = crm_pkg::FRAME_HEADER ^ crm_pkg::FRAME_LENGTH;
        for (int b = 0; b < 8; b++)
        begin
            checksum_next = checksum_next ^ lane.x[8*b +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            response_reg <= lane.x;
            checksum_reg <= checksum_next;
        end
    end

    assign resp.valid          = valid_reg;
    assign resp.response       = response_reg;
    assign resp.frame_checksum = checksum_reg;

endmodule

`default_nettype wire

@@ hw/rtl/challenge_response_mixer_core.sv @@
// Top level of the challenge-response mixer pipeline.
//
// Channel   Direction   Payload                           Transfer when
// chal      in          challenge[63:0]                   chal.valid && chal.ready
// resp      out         response[63:0], frame_checksum    resp.valid && resp.ready
//
// One challenge is taken per cycle unless the pipeline holds (see below).
// Each round occupies four stages, one 64-bit add per stage, which sets the depth.
// Reset clears only the valid bits of the stages; data registers are not reset.
// When a response waits and resp.ready is low, the whole pipeline holds and
// chal.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module challenge_response_mixer_core
#(
    parameter int ROUND_COUNT = 33
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    crm_chal_if.sink    chal,
    crm_resp_if.source  resp
);

    logic           advance;
    crm_pkg::lane_t lanes [0:ROUND_COUNT];

    crm_prep u_prep
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .chal    (chal),
        .lane    (lanes[0])
    );

    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        crm_round
        #(
            .ROUND_INDEX (r)
        )
        u_round
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .lane_in  (lanes[r]),
            .lane_out (lanes[r + 1])
        );
    end

    crm_out u_out
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .lane    (lanes[ROUND_COUNT]),
        .advance (advance),
        .resp    (resp)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for the challenge-response mixer: stimulus, prediction and response checks.
`timescale 1ns / 1ps

module tb_top;

    localparam int ROUND_COUNT     = 33;
    localparam int PIPE_LATENCY    = 4 * ROUND_COUNT + 2;
    localparam int IDLE_LIMIT      = 4000;
    localparam int RANDOM_ITEMS    = 650;
    localparam int DRAIN_SPACING   = 160;
    localparam int PHASE_CYCLES    = 256;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_LONG
    } stall_mode_t;

    typedef struct {
        logic [63:0] challenge;
        bit          drain_first;
    } challenge_item_t;

    typedef struct {
        logic [63:0] response;
        logic [7:0]  frame_checksum;
    } response_t;

    logic clk;
    logic rst_n;

    crm_chal_if chal_bus ();
    crm_resp_if resp_bus ();

    challenge_response_mixer_core #(
        .ROUND_COUNT(ROUND_COUNT)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .chal  (chal_bus),
        .resp  (resp_bus)
    );

    challenge_item_t pending_challenges[$];
    response_t       expected_responses[$];

    logic chal_taken;
    int   gap_left;
    int   burst_left;
    int   stall_left;
    int   cycle_count;
    int   idle_cycles;
    int   mismatch_count;
    int   accepted_count;
    int   checked_count;
    int   drain_count;
    int   directed_count;
    int   total_items;

    function automatic logic [63:0] key_rotated(input int unsigned amount);
        int unsigned s;
        s = amount % 64;
        if (s == 0)
            return crm_pkg::MIX_KEY;
        return (crm_pkg::MIX_KEY << s) | (crm_pkg::MIX_KEY >> (64 - s));
    endfunction

    function automatic logic [63:0] mixed_response(input logic [63:0] challenge);
        logic [63:0] x;
        logic [63:0] y;
        x = (challenge + crm_pkg::MIX_KEY) ^ crm_pkg::MIX_KEY;
        y = '0;
        for (int r = 0; r < ROUND_COUNT; r++)
        begin
            x = (x + y) ^ key_rotated(r);
            y = crm_pkg::MIX_KEY ^ (crm_pkg::MIX_KEY + (x ^ crm_pkg::MIX_KEY));
            x = x ^ y;
            x = x + ((crm_pkg::MIX_KEY + x) ^ y);
        end
        return x;
    endfunction

    function automatic logic [7:0] frame_checksum_of(input logic [63:0] response);
        logic [7:0] sum;
        sum = crm_pkg::FRAME_HEADER ^ crm_pkg::FRAME_LENGTH;
        for (int b = 0; b < 8; b++)
            sum = sum ^ response[8 * b +: 8];
        return sum;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s at %0t: got %h, want %h", what, $realtime, got, want);
        mismatch_count++;
    endtask

    always #2 clk = ~clk;

    // Records transfers on both channels and checks each response against the oldest prediction.
    always @(posedge clk)
    begin
        response_t want;
        if (!rst_n)
        begin
            chal_taken <= 1'b0;
        end
        else
        begin
            chal_taken <= chal_bus.valid && chal_bus.ready;
            cycle_count <= cycle_count + 1;
            if (chal_bus.valid && chal_bus.ready)
            begin
                want.response = mixed_response(chal_bus.challenge);
                want.frame_checksum = frame_checksum_of(want.response);
                expected_responses.push_back(want);
                accepted_count <= accepted_count + 1;
            end
            if (resp_bus.valid && resp_bus.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    report_mismatch("unexpected response", resp_bus.response, 64'h0);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (resp_bus.response !== want.response)
                        report_mismatch("response", resp_bus.response, want.response);
                    if (resp_bus.frame_checksum !== want.frame_checksum)
                        report_mismatch("frame_checksum", {56'h0, resp_bus.frame_checksum},
                                        {56'h0, want.frame_checksum});
                end
                checked_count <= checked_count + 1;
            end
            if ((chal_bus.valid && chal_bus.ready) || (resp_bus.valid && resp_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Challenge driver: bursts with gaps, and a full drain before items marked for it.
    always @(negedge clk)
    begin
        challenge_item_t item;
        if (!rst_n)
        begin
            chal_bus.valid <= 1'b0;
        end
        else if (!(chal_bus.valid && !chal_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                chal_bus.valid <= 1'b0;
            end
            else if (pending_challenges.size() != 0 &&
                     !(pending_challenges[0].drain_first && expected_responses.size() != 0))
            begin
                item = pending_challenges.pop_front();
                if (item.drain_first)
                    drain_count <= drain_count + 1;
                chal_bus.valid <= 1'b1;
                chal_bus.challenge <= item.challenge;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                chal_bus.valid <= 1'b0;
            end
        end
    end

    // Response sink: the stall style steps through four modes, one per PHASE_CYCLES phase.
    always @(negedge clk)
    begin
        stall_mode_t mode;
        mode = stall_mode_t'((cycle_count / PHASE_CYCLES) % 4);
        if (!rst_n)
        begin
            resp_bus.ready <= 1'b0;
        end
        else
        begin
            case (mode)
                STALL_NONE:    resp_bus.ready <= 1'b1;
                STALL_RANDOM:  resp_bus.ready <= ($urandom_range(0, 9) < 7);
                STALL_PATTERN: resp_bus.ready <= (cycle_count % 4 == 1);
                default:
                begin
                    if (stall_left != 0)
                    begin
                        stall_left <= stall_left - 1;
                        resp_bus.ready <= 1'b0;
                    end
                    else
                    begin
                        resp_bus.ready <= 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            stall_left <= $urandom_range(5, 40);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer.", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        challenge_item_t item;
        logic [63:0]     value;
        logic [7:0]      pattern;
        clk = 1'b0;
        rst_n = 1'b0;
        chal_bus.valid = 1'b0;
        chal_bus.challenge = '0;
        resp_bus.ready = 1'b0;
        chal_taken = 1'b0;
        gap_left = 0;
        burst_left = 4;
        stall_left = 0;
        cycle_count = 0;
        idle_cycles = 0;
        mismatch_count = 0;
        accepted_count = 0;
        checked_count = 0;
        drain_count = 0;

        item.drain_first = 1'b0;
        pending_challenges.push_back('{64'h0, 1'b0});
        pending_challenges.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b0});
        pending_challenges.push_back('{64'h1, 1'b0});
        pending_challenges.push_back('{64'h8000_0000_0000_0000, 1'b0});
        pending_challenges.push_back('{crm_pkg::MIX_KEY, 1'b0});
        pending_challenges.push_back('{-crm_pkg::MIX_KEY, 1'b0});
        pending_challenges.push_back('{-crm_pkg::MIX_KEY - 64'h1, 1'b0});
        pending_challenges.push_back('{~crm_pkg::MIX_KEY, 1'b0});
        pending_challenges.push_back('{64'h5555_5555_5555_5555, 1'b0});
        pending_challenges.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 1'b0});
        pending_challenges.push_back('{64'h0000_0000_FFFF_FFFF, 1'b0});
        pending_challenges.push_back('{64'hFFFF_FFFF_0000_0000, 1'b0});
        pending_challenges.push_back('{64'h0123_4567_89AB_CDEF, 1'b0});
        for (int b = 0; b < 8; b++)
            pending_challenges.push_back('{64'hFF << (8 * b), 1'b0});
        directed_count = pending_challenges.size();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 9))
                6:       value = 64'h1 << $urandom_range(0, 63);
                7:       value = ~(64'h1 << $urandom_range(0, 63));
                8:       value = -crm_pkg::MIX_KEY + {{32{1'b0}}, $urandom_range(0, 255)}
                                 - 64'd128;
                9:
                begin
                    pattern = 8'($urandom);
                    value = {8{pattern}};
                end
                default: value = {$urandom, $urandom};
            endcase
            item.challenge = value;
            item.drain_first = (n % DRAIN_SPACING == 0);
            pending_challenges.push_back(item);
        end
        total_items = pending_challenges.size();

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (accepted_count != total_items || expected_responses.size() != 0);
        repeat (PIPE_LATENCY + 16) @(posedge clk);

        if (expected_responses.size() != 0)
            report_mismatch("responses still outstanding", 64'(expected_responses.size()),
                            64'h0);
        $display("Sent %0d challenges (%0d directed, rest random with bursts and gaps).",
                 accepted_count, directed_count);
        $display("Checked %0d responses under four stall styles, %0d full drains.",
                 checked_count, drain_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/crm_pkg.sv
hw/rtl/crm_chal_if.sv
hw/rtl/crm_resp_if.sv
hw/rtl/crm_prep.sv
hw/rtl/crm_round.sv
hw/rtl/crm_out.sv
hw/rtl/challenge_response_mixer_core.sv
tb/sv/tb_top.sv
